[hdl/rbd_pkg.sv]
// shared types and constants for the record block deserializer
`default_nettype none
package rbd_pkg;

	localparam int MAX_FIELDS     = 16;
	localparam int DATE_BYTES     = 8;
	localparam int DATETIME_BYTES = 14;

	// field type codes
	localparam logic [2:0] FT_I1       = 3'd0;
	localparam logic [2:0] FT_I2       = 3'd1;
	localparam logic [2:0] FT_I4       = 3'd2;
	localparam logic [2:0] FT_I8       = 3'd3;
	localparam logic [2:0] FT_NULLSTR  = 3'd4;
	localparam logic [2:0] FT_LENSTR   = 3'd5;
	localparam logic [2:0] FT_DATE     = 3'd6;
	localparam logic [2:0] FT_DATETIME = 3'd7;

	// configuration register indexes
	localparam logic [1:0] CFG_FIELD_COUNT = 2'd0;
	localparam logic [1:0] CFG_TYPE_LIST   = 2'd1;

	localparam int CFG_DATA_W = 45;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_FIELD,
		PH_CHARS
	} phase_t;

	typedef struct packed {
		logic [7:0]  record_index;
		logic [3:0]  field_index;
		logic [2:0]  field_type;
		logic [63:0] int_value;
		logic [7:0]  char_byte;
		logic        char_valid;
		logic        field_end;
		logic        record_end;
		logic        block_end;
	} result_t;

endpackage
`default_nettype wire

[hdl/rbd_outbuf.sv]
// result register with skid entry so the input side keeps moving under a stall
`default_nettype none
module rbd_outbuf
	import rbd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         push_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    pop;

	assign pop        = out_valid_q && out_ready;
	assign push_ready = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/record_block_deserializer.sv]
// top level: byte stream of record blocks in, one field event per result out
//
// in channel: one data_byte per request (in_valid/in_ready). the first byte
// of a block is its unsigned record count; each record is a 4-byte id
// followed by the configured fields.
// out channel: one result per request (out_valid/out_ready); integer fields give one result
// on their last byte, text and date fields one per character, the last one marked field_end,
// and zero-ended text an end mark on its zero byte; a zero record count gives one block_end.
// cfg channel: cfg_index 0 writes user_field_count, 1 writes field_type_list;
// write only while no result is waiting, the next byte sees the new value.
// cfg_ready is always high.
// result: registered in the result buffer when its byte is taken.
// throughput: one byte per cycle while in_ready is high, set by the single decode stage
// between the parser state registers and the result register.
// stall: a two-entry result buffer takes one more result while the receiver
// holds off; in_ready drops when both entries are full.
// reset: parser waits for a block header, registers read zero, output empty.
`default_nettype none
module record_block_deserializer
	import rbd_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [7:0]              data_byte,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [7:0]                   record_index,
	output logic [3:0]                   field_index,
	output logic [2:0]                   field_type,
	output logic signed [63:0]           int_value,
	output logic [7:0]                   char_byte,
	output logic                         char_valid,
	output logic                         field_end,
	output logic                         record_end,
	output logic                         block_end,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

	logic [3:0]            user_field_count_q;
	logic [CFG_DATA_W-1:0] field_type_list_q;

	phase_t      phase_q, phase_n;
	logic [7:0]  records_total_q, records_total_n;
	logic [7:0]  record_count_q, record_count_n;
	logic [3:0]  field_pos_q, field_pos_n;
	logic [7:0]  byte_count_q, byte_count_n;
	logic [7:0]  string_length_q, string_length_n;
	logic [63:0] accumulator_q, accumulator_n;

	logic        in_accept;
	logic        res_vld;
	result_t     res;
	result_t     out_data;
	logic [2:0]  ftype;
	logic [4:0]  fields_per_rec;
	logic [63:0] acc_tmp;
	logic [7:0]  bc_inc;
	logic [3:0]  fp_inc;
	logic [7:0]  rc_inc;
	logic        e_fend;
	logic        e_chv;
	logic [7:0]  e_ch;
	logic [63:0] e_ival;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_field_count_q <= '0;
			field_type_list_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FIELD_COUNT: user_field_count_q <= cfg_data[3:0];
				CFG_TYPE_LIST:   field_type_list_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// type of the current field, the id is always a 4-byte integer
	always_comb begin
		ftype = FT_I4;
		for (int k = 1; k < 16; k++) begin
			if (field_pos_q == 4'(k)) begin
				ftype = field_type_list_q[3*(k-1) +: 3];
			end
		end
	end

	always_comb begin
		if ({1'b0, user_field_count_q} + 5'd1 > 5'(MAX_FIELDS)) begin
			fields_per_rec = 5'(MAX_FIELDS);
		end else begin
			fields_per_rec = {1'b0, user_field_count_q} + 5'd1;
		end
	end

	assign bc_inc = (byte_count_q < 8'd255) ? byte_count_q + 8'd1 : byte_count_q;

	// place the new byte into the accumulator lane
	always_comb begin
		acc_tmp = accumulator_q;
		for (int i = 0; i < 8; i++) begin
			if (byte_count_q == 8'(i)) begin
				acc_tmp[8*i +: 8] = accumulator_q[8*i +: 8] | data_byte;
			end
		end
	end

	// next state and result
	always_comb begin
		phase_n         = phase_q;
		records_total_n = records_total_q;
		record_count_n  = record_count_q;
		field_pos_n     = field_pos_q;
		byte_count_n    = byte_count_q;
		string_length_n = string_length_q;
		accumulator_n   = accumulator_q;
		res_vld         = 1'b0;
		res             = '0;
		e_fend          = 1'b0;
		e_chv           = 1'b0;
		e_ch            = '0;
		e_ival          = '0;
		fp_inc          = field_pos_q + 4'd1;
		rc_inc          = record_count_q + 8'd1;

		if (phase_q == PH_HEADER) begin
			if (data_byte == 8'd0) begin
				res_vld         = 1'b1;
				res.block_end   = 1'b1;
			end else begin
				records_total_n = data_byte;
				record_count_n  = '0;
				field_pos_n     = '0;
				byte_count_n    = '0;
				string_length_n = '0;
				accumulator_n   = '0;
				phase_n         = PH_FIELD;
			end
		end else begin
			case (ftype)
				FT_I1, FT_I2, FT_I4, FT_I8: begin
					if ({1'b0, byte_count_q} + 9'd1 >= (9'd1 << ftype[1:0])) begin
						res_vld = 1'b1;
						e_fend  = 1'b1;
						case (ftype)
							FT_I1:   e_ival = {{56{acc_tmp[7]}}, acc_tmp[7:0]};
							FT_I2:   e_ival = {{48{acc_tmp[15]}}, acc_tmp[15:0]};
							FT_I4:   e_ival = {{32{acc_tmp[31]}}, acc_tmp[31:0]};
							default: e_ival = acc_tmp;
						endcase
					end else begin
						accumulator_n = acc_tmp;
						byte_count_n  = bc_inc;
					end
				end
				FT_NULLSTR: begin
					res_vld = 1'b1;
					if (data_byte == 8'd0) begin
						e_fend = 1'b1;
					end else begin
						e_chv = 1'b1;
						e_ch  = data_byte;
					end
				end
				FT_LENSTR: begin
					if (phase_q != PH_CHARS) begin
						string_length_n = data_byte;
						byte_count_n    = '0;
						if (data_byte == 8'd0) begin
							res_vld = 1'b1;
							e_fend  = 1'b1;
						end else begin
							phase_n = PH_CHARS;
						end
					end else begin
						byte_count_n = bc_inc;
						res_vld      = 1'b1;
						e_chv        = 1'b1;
						e_ch         = data_byte;
						e_fend       = bc_inc >= string_length_q;
					end
				end
				FT_DATE: begin
					byte_count_n = bc_inc;
					res_vld      = 1'b1;
					e_chv        = 1'b1;
					e_ch         = data_byte;
					e_fend       = bc_inc >= 8'(DATE_BYTES);
				end
				FT_DATETIME: begin
					byte_count_n = bc_inc;
					res_vld      = 1'b1;
					e_chv        = 1'b1;
					e_ch         = data_byte;
					e_fend       = bc_inc >= 8'(DATETIME_BYTES);
				end
				default: ;
			endcase

			if (res_vld) begin
				res.record_index = record_count_q;
				res.field_index  = field_pos_q;
				res.field_type   = ftype;
				res.int_value    = e_ival;
				res.char_byte    = e_ch;
				res.char_valid   = e_chv;
				res.field_end    = e_fend;
				if (e_fend) begin
					byte_count_n    = '0;
					accumulator_n   = '0;
					string_length_n = '0;
					phase_n         = PH_FIELD;
					// wrap past the last position also closes the record
					if (fp_inc == 4'd0 || {1'b0, fp_inc} >= fields_per_rec) begin
						res.record_end = 1'b1;
						field_pos_n    = '0;
						if (rc_inc >= records_total_q) begin
							res.block_end  = 1'b1;
							phase_n        = PH_HEADER;
							record_count_n = '0;
						end else begin
							record_count_n = rc_inc;
						end
					end else begin
						field_pos_n = fp_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HEADER;
			records_total_q <= '0;
			record_count_q  <= '0;
			field_pos_q     <= '0;
			byte_count_q    <= '0;
			string_length_q <= '0;
			accumulator_q   <= '0;
		end else if (in_accept) begin
			phase_q         <= phase_n;
			records_total_q <= records_total_n;
			record_count_q  <= record_count_n;
			field_pos_q     <= field_pos_n;
			byte_count_q    <= byte_count_n;
			string_length_q <= string_length_n;
			accumulator_q   <= accumulator_n;
		end
	end

	rbd_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_accept && res_vld),
		.push_data  (res),
		.push_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	assign record_index = out_data.record_index;
	assign field_index  = out_data.field_index;
	assign field_type   = out_data.field_type;
	assign int_value    = $signed(out_data.int_value);
	assign char_byte    = out_data.char_byte;
	assign char_valid   = out_data.char_valid;
	assign field_end    = out_data.field_end;
	assign record_end   = out_data.record_end;
	assign block_end    = out_data.block_end;

	// a full skid entry only exists behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("skid entry full with empty output register");

	// waiting for a header means positions were rewound
	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> (record_count_q == 8'd0 && field_pos_q == 4'd0))
		else $error("header phase with stale record or field position");

	// character phase is only entered on a nonzero length prefix
	a_chars_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CHARS |-> string_length_q != 8'd0)
		else $error("character phase with zero string length");

	// a block end request closes a field, or is the bare end of an empty block
	a_bend_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && block_end) |-> (field_end || (record_index == 8'd0 && !char_valid)))
		else $error("block end without field end on a nonempty block");

endmodule
`default_nettype wire

[bench/tb.sv]
// self-checking testbench for the record block deserializer
`timescale 1ns / 100ps

module tb;
	import rbd_pkg::*;

	// register index with no register behind it, writes are dropped
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS = 150;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] record_index;
	logic [3:0] field_index;
	logic [2:0] field_type;
	logic signed [63:0] int_value;
	logic [7:0] char_byte;
	logic char_valid;
	logic field_end;
	logic record_end;
	logic block_end;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_FIELD_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	record_block_deserializer DUT (.*);

	// parser copy: configuration and block state
	logic [3:0] num_fields = '0;
	logic [CFG_DATA_W-1:0] type_list = '0;
	phase_t blk_phase = PH_HEADER;
	logic [7:0] blk_records = '0;
	logic [7:0] blk_record = '0;
	logic [3:0] blk_field = '0;
	logic [7:0] blk_count = '0;
	logic [7:0] blk_strlen = '0;
	logic [63:0] blk_acc = '0;

	result_t field_events[$];
	int failures = 0;
	int bytes_sent = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_pct = 0;
	int cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** record_block_deserializer: FAILED **");
			$finish;
		end
	end

	// receiver: stall rate changes from one stretch to the next
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(30, 300);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end else begin
			stall_left--;
		end
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic void post_event(logic [2:0] ftype, logic [63:0] ival,
			logic [7:0] ch, logic chv, logic fend);
		result_t ev;
		ev = '0;
		ev.record_index = blk_record;
		ev.field_index = blk_field;
		ev.field_type = ftype;
		ev.int_value = ival;
		ev.char_byte = ch;
		ev.char_valid = chv;
		ev.field_end = fend;
		if (fend) begin
			blk_count = '0;
			blk_acc = '0;
			blk_strlen = '0;
			blk_phase = PH_FIELD;
			blk_field = blk_field + 4'd1;
			if (blk_field == 4'd0 || int'(blk_field) >= int'(num_fields) + 1) begin
				ev.record_end = 1'b1;
				blk_field = '0;
				blk_record = blk_record + 8'd1;
				if (blk_record >= blk_records) begin
					ev.block_end = 1'b1;
					blk_phase = PH_HEADER;
					blk_record = '0;
				end
			end
		end
		field_events.push_back(ev);
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		logic [2:0] ftype;
		int nbytes;
		int flen;
		logic [63:0] v;
		result_t ev;
		if (blk_phase == PH_HEADER) begin
			if (b == 8'd0) begin
				ev = '0;
				ev.block_end = 1'b1;
				field_events.push_back(ev);
			end else begin
				blk_records = b;
				blk_record = '0;
				blk_field = '0;
				blk_count = '0;
				blk_strlen = '0;
				blk_acc = '0;
				blk_phase = PH_FIELD;
			end
		end else begin
			ftype = (blk_field == 4'd0) ? FT_I4 : type_list[3*(blk_field-1) +: 3];
			if (ftype <= FT_I8) begin
				nbytes = 1 << ftype;
				if (blk_count < 8'd8)
					blk_acc |= 64'(b) << (8*blk_count);
				if (int'(blk_count) + 1 >= nbytes) begin
					case (ftype)
						FT_I1: v = {{56{blk_acc[7]}}, blk_acc[7:0]};
						FT_I2: v = {{48{blk_acc[15]}}, blk_acc[15:0]};
						FT_I4: v = {{32{blk_acc[31]}}, blk_acc[31:0]};
						default: v = blk_acc;
					endcase
					post_event(ftype, v, 8'd0, 1'b0, 1'b1);
				end else if (blk_count < 8'd255) begin
					blk_count++;
				end
			end else if (ftype == FT_NULLSTR) begin
				if (b == 8'd0)
					post_event(ftype, '0, 8'd0, 1'b0, 1'b1);
				else
					post_event(ftype, '0, b, 1'b1, 1'b0);
			end else if (ftype == FT_LENSTR && blk_phase != PH_CHARS) begin
				blk_strlen = b;
				blk_count = '0;
				if (b == 8'd0)
					post_event(ftype, '0, 8'd0, 1'b0, 1'b1);
				else
					blk_phase = PH_CHARS;
			end else begin
				// counted text and date fields: a count that reaches or passes the length ends the field
				if (ftype == FT_LENSTR)
					flen = int'(blk_strlen);
				else if (ftype == FT_DATE)
					flen = DATE_BYTES;
				else
					flen = DATETIME_BYTES;
				if (blk_count < 8'd255)
					blk_count++;
				post_event(ftype, '0, b, 1'b1, int'(blk_count) >= flen);
			end
		end
	endfunction

	function automatic void check_value(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (field_events.size() == 0) begin
				$error("result with no field event pending");
				failures++;
			end else begin
				want = field_events.pop_front();
				check_value("record_index", want.record_index, record_index);
				check_value("field_index", want.field_index, field_index);
				check_value("field_type", want.field_type, field_type);
				check_value("int_value", want.int_value, int_value);
				check_value("char_byte", want.char_byte, char_byte);
				check_value("char_valid", want.char_valid, char_valid);
				check_value("field_end", want.field_end, field_end);
				check_value("record_end", want.record_end, record_end);
				check_value("block_end", want.block_end, block_end);
			end
		end
	end

	// one request on the byte channel, then maybe a gap before the next burst
	task automatic send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decode_byte(b);
		bytes_sent++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4))
				@(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
				: $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	// bytes go out in the order written, leftmost first
	task automatic send_bytes(input logic [255:0] seq, input int n);
		for (int k = n - 1; k >= 0; k--)
			send_byte(seq[8*k +: 8]);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (field_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_FIELD_COUNT)
			num_fields = val[3:0];
		else if (idx == CFG_TYPE_LIST)
			type_list = val;
	endtask

	task automatic send_field(input logic [2:0] ftype);
		int nbytes;
		int len;
		logic [63:0] v;
		case (ftype)
			FT_I1, FT_I2, FT_I4, FT_I8: begin
				nbytes = 1 << ftype;
				v = {$urandom, $urandom};
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = '1;
					2: v = 64'd1 << (8*nbytes - 1);
					3: v = (64'd1 << (8*nbytes - 1)) - 64'd1;
					default: ;
				endcase
				for (int k = 0; k < nbytes; k++)
					send_byte(v[8*k +: 8]);
			end
			FT_NULLSTR: begin
				len = $urandom_range(0, 6);
				repeat (len)
					send_byte(8'($urandom_range(1, 255)));
				send_byte(8'd0);
			end
			FT_LENSTR: begin
				len = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 6);
				send_byte(len[7:0]);
				repeat (len)
					send_byte(8'($urandom_range(0, 255)));
			end
			FT_DATE: repeat (DATE_BYTES) send_byte(8'($urandom_range(0, 255)));
			default: repeat (DATETIME_BYTES) send_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic send_block(input int nrec);
		send_byte(nrec[7:0]);
		repeat (nrec) begin
			send_field(FT_I4);
			for (int p = 1; p <= int'(num_fields); p++)
				send_field(type_list[3*(p-1) +: 3]);
		end
	endtask

	// zero bytes close every field type, so the stream gets back to a header
	task automatic finish_block();
		while (blk_phase != PH_HEADER)
			send_byte(8'd0);
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 24);
		repeat (n) begin
			if (blk_phase == PH_HEADER)
				send_byte(8'($urandom_range(0, 3)));
			else
				send_byte(8'($urandom_range(0, 255)));
		end
		finish_block();
	endtask

	task automatic test_empty_blocks();
		write_reg(CFG_FIELD_COUNT, '0);
		write_reg(CFG_TYPE_LIST, '0);
		send_bytes({8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h80,
			8'h02, 8'hff, 8'hff, 8'hff, 8'h7f, 8'hff, 8'hff, 8'hff, 8'hff}, 16);
	endtask

	task automatic test_integer_fields();
		write_reg(CFG_FIELD_COUNT, 45'd4);
		write_reg(CFG_TYPE_LIST, {33'd0, FT_I1, FT_I8, FT_I2, FT_I1});
		send_bytes({8'h01, 8'h78, 8'h56, 8'h34, 8'h12, 8'h80, 8'hff, 8'h7f,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h7f}, 17);
	endtask

	task automatic test_text_fields();
		write_reg(CFG_FIELD_COUNT, 45'd4);
		write_reg(CFG_TYPE_LIST, {33'd0, FT_DATETIME, FT_DATE, FT_LENSTR, FT_NULLSTR});
		// empty strings first, then short ones
		send_bytes({8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 7);
		send_field(FT_DATE);
		send_field(FT_DATETIME);
		send_bytes({8'h02, 8'h00, 8'h00, 8'h00, 8'h41, 8'hff, 8'h00, 8'h02, 8'h00, 8'hff}, 10);
		send_field(FT_DATE);
		send_field(FT_DATETIME);
	endtask

	task automatic test_reconfig_mid_block();
		write_reg(CFG_FIELD_COUNT, 45'd2);
		write_reg(CFG_TYPE_LIST, {39'd0, FT_DATE, FT_I8});
		send_bytes({8'h01, 8'h05, 8'h00, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33}, 8);
		// shorter integer, the next byte finishes it
		write_reg(CFG_TYPE_LIST, {39'd0, FT_DATE, FT_I2});
		send_bytes({8'h84, 8'h61, 8'h62, 8'h63}, 4);
		// field position now past the field count
		write_reg(CFG_FIELD_COUNT, 45'd1);
		finish_block();
		write_reg(CFG_TYPE_LIST, {42'd0, FT_DATETIME});
		send_bytes({8'h01, 8'h09, 8'h00, 8'h00, 8'h00}, 5);
		repeat (10)
			send_byte(8'($urandom_range(0, 255)));
		write_reg(CFG_TYPE_LIST, {42'd0, FT_DATE});
		send_byte(8'h5a);
		finish_block();
	endtask

	task automatic test_unused_register();
		write_reg(CFG_UNUSED, '1);
		send_block(2);
	endtask

	task automatic test_longest_block();
		write_reg(CFG_FIELD_COUNT, '0);
		send_block(255);
	endtask

	task automatic test_random_stream();
		int start;
		int nrec;
		logic [CFG_DATA_W-1:0] types;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_ITEMS) begin
			if (bytes_sent == start || $urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: write_reg(CFG_FIELD_COUNT, '0);
					1: write_reg(CFG_FIELD_COUNT, 45'd15);
					default: write_reg(CFG_FIELD_COUNT, 45'($urandom_range(0, 15)));
				endcase
				types = CFG_DATA_W'({$urandom, $urandom});
				case ($urandom_range(0, 4))
					0: types = '0;
					1: types = '1;
					default: ;
				endcase
				write_reg(CFG_TYPE_LIST, types);
			end
			if ($urandom_range(0, 19) == 0)
				drain_results();
			if ($urandom_range(0, 6) == 0) begin
				send_noise();
			end else begin
				if ($urandom_range(0, 9) == 0)
					nrec = 0;
				else
					nrec = (num_fields > 4'd6) ? $urandom_range(1, 2) : $urandom_range(1, 5);
				send_block(nrec);
			end
		end
	endtask

	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_blocks();
		test_integer_fields();
		test_text_fields();
		test_reconfig_mid_block();
		test_unused_register();
		test_longest_block();
		test_random_stream();
		drain_results();
		if (failures == 0)
			$display("** record_block_deserializer: PASSED **");
		else
			$display("** record_block_deserializer: FAILED **");
		$finish;
	end

endmodule
